/* src/ptw_pkg.sv */
`default_nettype none

package ptw_pkg;

    localparam int VA_BITS    = 48;
    localparam int ADDR_W     = 64;
    localparam int IDX_W      = 9;
    localparam int LEVEL_W    = 2;
    localparam int KIND_W     = 2;
    localparam int S_TDATA_W  = 128;
    localparam int M_TDATA_W  = 72;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_REPLY = 1'b1;

    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FAULT = 2'd2;

    localparam logic [1:0] DESC_BLOCK = 2'd1;
    localparam logic [1:0] DESC_TABLE = 2'd3;

    localparam logic [LEVEL_W-1:0] LEVEL_0 = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_1 = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_2 = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_3 = 2'd3;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] virtual_address;
        logic [ADDR_W-1:0] descriptor;
    } item_t;

    typedef struct packed {
        logic               active;
        logic [LEVEL_W-1:0] level;
        logic [VA_BITS-1:0] held_va;
    } walk_state_t;

    typedef struct packed {
        logic               emit;
        logic [KIND_W-1:0]  kind;
        logic [ADDR_W-1:0]  address;
        logic [LEVEL_W-1:0] level;
    } step_result_t;

    function automatic logic [IDX_W-1:0] level_index(
        input logic [VA_BITS-1:0] va,
        input logic [LEVEL_W-1:0] lvl
    );
        logic [ADDR_W-1:0] wide;
        logic [IDX_W-1:0]  idx;
        wide = {{(ADDR_W-VA_BITS){1'b0}}, va};
        case (lvl)
            LEVEL_0: idx = wide[47:39];
            LEVEL_1: idx = wide[38:30];
            LEVEL_2: idx = wide[29:21];
            LEVEL_3: idx = wide[20:12];
            default: idx = '0;
        endcase
        return idx;
    endfunction

    function automatic logic [ADDR_W-1:0] table_offset(input logic [IDX_W-1:0] idx);
        return {{(ADDR_W-IDX_W-3){1'b0}}, idx, 3'b000};
    endfunction

endpackage

`default_nettype wire

/* src/four_level_page_table_walker.sv */
// The input register captures each accepted transaction; its result, if it has one, then
// goes to the result register that drives m_tvalid. Throughput: one transaction per cycle
// unless m_tready stalls the result register; one descriptor decode and one 64-bit add per
// item sit between the input register and the result register. Each read request must be
// answered before the walk advances, so memory latency sets the walk time.
// Reset clears the walk state, the root table base and both stage valid flags.
`default_nettype none

module four_level_page_table_walker
    import ptw_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [ADDR_W-1:0]    cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // virtual_address [63:0], descriptor [127:64]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // cmd [0]
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // address [63:0], level [65:64], zero [71:66]
    output logic [M_TDATA_W-1:0]      m_tdata,
    // kind [1:0]
    output logic [KIND_W-1:0]         m_tuser
);

    logic               item_valid;
    item_t              item;
    logic               take;
    logic               load;
    step_result_t       res;
    walk_state_t        state_reg;
    walk_state_t        state_next;
    logic [ADDR_W-1:0]  root_base_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [KIND_W-1:0]  out_kind_reg;
    logic [ADDR_W-1:0]  out_address_reg;
    logic [LEVEL_W-1:0] out_level_reg;

    ptw_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    ptw_step u_step (
        .item       (item),
        .state      (state_reg),
        .root_base  (root_base_reg),
        .res        (res),
        .state_next (state_next)
    );

    assign take = item_valid && (!out_valid_reg || m_tready);
    assign load = take && res.emit;

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            root_base_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                state_reg <= state_next;
            end
            if (cfg_we)
            begin
                root_base_reg <= cfg_wdata;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_kind_reg    <= res.kind;
            out_address_reg <= res.address;
            out_level_reg   <= res.level;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {{(M_TDATA_W-ADDR_W-LEVEL_W){1'b0}}, out_level_reg, out_address_reg};

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == KIND_FAULT |-> out_address_reg == '0)
        else $error("fault result carries a nonzero address");

    a_active_follows_kind: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> state_reg.active == (out_kind_reg == KIND_READ))
        else $error("walk activity disagrees with the last result kind");

    a_read_level: assert property (@(posedge clk) disable iff (!rst_n)
        load && res.kind == KIND_READ |=> out_level_reg == state_reg.level)
        else $error("read request level differs from the walk level");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !out_valid_reg || m_tready)
        else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

/* src/ptw_in_reg.sv */
`default_nettype none

module ptw_in_reg
    import ptw_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    input  wire logic                 take,
    output logic                      item_valid,
    output item_t                     item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    assign s_tready = !valid_reg || take;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.cmd             <= s_tuser;
            item_reg.virtual_address <= s_tdata[63:0];
            item_reg.descriptor      <= s_tdata[127:64];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

/* src/ptw_step.sv */
`default_nettype none

module ptw_step
    import ptw_pkg::*;
(
    input  wire item_t             item,
    input  wire walk_state_t       state,
    input  wire logic [ADDR_W-1:0] root_base,
    output step_result_t           res,
    output walk_state_t            state_next
);

    logic [1:0]         entry_type;
    logic [LEVEL_W-1:0] next_level;
    logic [ADDR_W-1:0]  next_base;
    logic [ADDR_W-1:0]  page_base;
    logic [ADDR_W-1:0]  va_wide;
    logic [ADDR_W-1:0]  offset;
    logic [VA_BITS-1:0] start_va;

    assign entry_type = item.descriptor[1:0];
    assign next_level = state.level + LEVEL_1;
    assign next_base  = {item.descriptor[ADDR_W-1:2], 2'b00};
    assign page_base  = {item.descriptor[ADDR_W-1:12], 12'h000};
    assign va_wide    = {{(ADDR_W-VA_BITS){1'b0}}, state.held_va};
    assign start_va   = item.virtual_address[VA_BITS-1:0];

    always_comb
    begin
        case (state.level)
            LEVEL_1: offset = {34'd0, va_wide[29:0]};
            LEVEL_2: offset = {43'd0, va_wide[20:0]};
            default: offset = {52'd0, va_wide[11:0]};
        endcase
    end

    always_comb
    begin
        res        = '0;
        state_next = state;
        if (item.cmd == CMD_START)
        begin
            if (!state.active)
            begin
                state_next.active  = 1'b1;
                state_next.level   = LEVEL_0;
                state_next.held_va = start_va;
                res.emit           = 1'b1;
                res.kind           = KIND_READ;
                res.level          = LEVEL_0;
                res.address        = root_base
                                   + table_offset(level_index(start_va, LEVEL_0));
            end
        end
        else if (state.active)
        begin
            res.emit  = 1'b1;
            res.level = state.level;
            if (state.level != LEVEL_3 && entry_type == DESC_TABLE)
            begin
                state_next.level = next_level;
                res.kind         = KIND_READ;
                res.level        = next_level;
                res.address      = next_base
                                 + table_offset(level_index(state.held_va, next_level));
            end
            else
            begin
                state_next.active = 1'b0;
                if ((state.level inside {LEVEL_1, LEVEL_2} && entry_type == DESC_BLOCK)
                    || (state.level == LEVEL_3 && entry_type == DESC_TABLE))
                begin
                    res.kind    = KIND_DONE;
                    res.address = page_base + offset;
                end
                else
                begin
                    res.kind    = KIND_FAULT;
                    res.address = '0;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* sim/four_level_page_table_walker_tb.sv */
`default_nettype none

module four_level_page_table_walker_tb;
    import ptw_pkg::*;

    localparam logic [1:0] DESC_INVALID  = 2'd0;
    localparam logic [1:0] DESC_RESERVED = 2'd2;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 375;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ADDR_W-1:0]  address;
        logic [LEVEL_W-1:0] level;
    } walk_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [ADDR_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]    m_tuser;

    // Walker state as the testbench expects it.
    logic [ADDR_W-1:0]    root_base = '0;
    logic                 walk_busy = 1'b0;
    logic [LEVEL_W-1:0]   walk_lvl = LEVEL_0;
    logic [VA_BITS-1:0]   held_va = '0;

    walk_result_t walk_results_due[$];

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_left = 0;
    int errors = 0;
    int items_sent = 0;
    int results_sent = 0;
    int reads_seen = 0;
    int done_seen = 0;
    int faults_seen = 0;

    four_level_page_table_walker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    initial
    begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] table_step(
        input logic [VA_BITS-1:0] va,
        input logic [LEVEL_W-1:0] lvl
    );
        logic [ADDR_W-1:0] shifted;
        shifted = {16'h0, va} >> (39 - 9 * int'(lvl));
        return {52'h0, shifted[8:0], 3'b000};
    endfunction

    // Advances the expected walker state by one accepted transaction and
    // returns whether that transaction produces a result.
    function automatic bit predict_walk_step(
        input  logic              cmd,
        input  logic [ADDR_W-1:0] va,
        input  logic [ADDR_W-1:0] desc,
        output walk_result_t      res
    );
        logic [1:0]        dtype;
        logic [ADDR_W-1:0] off_mask;
        res = '0;
        if (cmd == CMD_START)
        begin
            if (walk_busy)
                return 1'b0;
            held_va = va[VA_BITS-1:0];
            walk_lvl = LEVEL_0;
            walk_busy = 1'b1;
            res.kind = KIND_READ;
            res.address = root_base + table_step(held_va, LEVEL_0);
            res.level = LEVEL_0;
            return 1'b1;
        end
        if (!walk_busy)
            return 1'b0;
        dtype = desc[1:0];
        if (walk_lvl != LEVEL_3 && dtype == DESC_TABLE)
        begin
            walk_lvl = walk_lvl + 1'b1;
            res.kind = KIND_READ;
            res.address = {desc[63:2], 2'b00} + table_step(held_va, walk_lvl);
            res.level = walk_lvl;
            return 1'b1;
        end
        walk_busy = 1'b0;
        res.level = walk_lvl;
        if ((walk_lvl == LEVEL_1 || walk_lvl == LEVEL_2) && dtype == DESC_BLOCK)
        begin
            off_mask = (walk_lvl == LEVEL_1) ? 64'h3FFF_FFFF : 64'h1F_FFFF;
            res.kind = KIND_DONE;
            res.address = {desc[63:12], 12'h000} + ({16'h0, held_va} & off_mask);
        end
        else if (walk_lvl == LEVEL_3 && dtype == DESC_TABLE)
        begin
            res.kind = KIND_DONE;
            res.address = {desc[63:12], 12'h000} + {52'h0, held_va[11:0]};
        end
        else
        begin
            res.kind = KIND_FAULT;
            res.address = '0;
        end
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        walk_result_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            case (m_tuser)
                KIND_READ: reads_seen++;
                KIND_DONE: done_seen++;
                default: faults_seen++;
            endcase
            if (walk_results_due.size() == 0)
            begin
                $error("unexpected transaction: kind %0d address %h level %0d",
                       m_tuser, m_tdata[63:0], m_tdata[65:64]);
                errors++;
            end
            else
            begin
                exp_res = walk_results_due.pop_front();
                if (m_tuser !== exp_res.kind)
                begin
                    $error("kind: expected %0d, actual %0d", exp_res.kind, m_tuser);
                    errors++;
                end
                if (m_tdata[63:0] !== exp_res.address)
                begin
                    $error("address: expected %h, actual %h",
                           exp_res.address, m_tdata[63:0]);
                    errors++;
                end
                if (m_tdata[65:64] !== exp_res.level)
                begin
                    $error("level: expected %0d, actual %0d",
                           exp_res.level, m_tdata[65:64]);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(
        input logic              cmd,
        input logic [ADDR_W-1:0] va,
        input logic [ADDR_W-1:0] desc
    );
        walk_result_t res;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {desc, va};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (predict_walk_step(cmd, va, desc, res))
        begin
            walk_results_due.push_back(res);
            results_sent++;
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (walk_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_root(input logic [ADDR_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        root_base = value;
    endtask

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ADDR_W-1:0] desc_of(input logic [1:0] dtype);
        logic [ADDR_W-1:0] d;
        d = rand64();
        d[1:0] = dtype;
        return d;
    endfunction

    // Mostly well-formed walks with random content, with a little noise
    // that lands out of turn or cuts a walk short.
    task automatic walk_traffic(input int target);
        int           stop_at;
        int           r;
        logic [1:0]   dtype;
        stop_at = results_sent + target;
        while (results_sent < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                send_item(logic'($urandom_range(1)), rand64(), rand64());
            end
            else if (!walk_busy)
            begin
                send_item(CMD_START, rand64(), rand64());
            end
            else
            begin
                r = $urandom_range(99);
                if (walk_lvl != LEVEL_3 && r < 70)
                    dtype = DESC_TABLE;
                else if (walk_lvl == LEVEL_3 && r < 75)
                    dtype = DESC_TABLE;
                else
                    dtype = 2'($urandom_range(2));
                send_item(CMD_REPLY, rand64(), desc_of(dtype));
            end
        end
    endtask

    task automatic test_directed();
        logic [ADDR_W-1:0] ones;
        ones = '1;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        write_root(ones);
        // Full page walk with root, address and descriptors at maximum; table sums wrap.
        send_item(CMD_START, ones, ones);
        send_item(CMD_REPLY, ones, ones);
        send_item(CMD_REPLY, '0, ones);
        send_item(CMD_REPLY, ones, ones);
        send_item(CMD_REPLY, ones, ones);
        wait_idle();
        write_root('0);
        // A block descriptor at level 0 is a fault, then a reply with no walk.
        send_item(CMD_START, '0, '0);
        send_item(CMD_REPLY, '0, {62'h0, DESC_BLOCK});
        send_item(CMD_REPLY, ones, {{62{1'b1}}, DESC_TABLE});
        // A second start during a walk is dropped; the walk ends in a 1 GB block.
        send_item(CMD_START, 64'h0000_8040_2010_0A5A, '0);
        send_item(CMD_START, ones, ones);
        send_item(CMD_REPLY, '0, 64'h0000_0000_1234_5003);
        send_item(CMD_REPLY, '0, 64'hFFFF_FFFF_C000_0FFD);
        // A 2 MB block.
        send_item(CMD_START, 64'hFFFF_7FFF_FFFF_FFFF, '0);
        send_item(CMD_REPLY, '0, 64'h8000_0000_0000_0007);
        send_item(CMD_REPLY, '0, 64'h0000_7FFF_FFFF_FFFF);
        send_item(CMD_REPLY, '0, 64'hFFFF_FFFF_FFE0_0001);
        // A root base change in mid-walk only affects the next start.
        send_item(CMD_START, 64'h0000_5555_AAAA_5555, '0);
        wait_idle();
        write_root(64'hFFFF_FFFF_FFFF_F000);
        send_item(CMD_REPLY, '0, desc_of(DESC_TABLE));
        send_item(CMD_REPLY, '0, desc_of(DESC_TABLE));
        send_item(CMD_REPLY, '0, desc_of(DESC_TABLE));
        send_item(CMD_REPLY, '0, desc_of(DESC_BLOCK));
        // Invalid and reserved descriptor types fault.
        send_item(CMD_START, 64'h0000_AAAA_5555_AAAA, '0);
        send_item(CMD_REPLY, '0, desc_of(DESC_INVALID));
        send_item(CMD_START, 64'h0000_0123_4567_89AB, '0);
        send_item(CMD_REPLY, '0, desc_of(DESC_TABLE));
        send_item(CMD_REPLY, '0, desc_of(DESC_RESERVED));
        wait_idle();
    endtask

    task automatic test_random_phase(
        input int                sender_pct,
        input int                receiver_pct,
        input logic [ADDR_W-1:0] base
    );
        write_root(base);
        sender_idle_pct = sender_pct;
        receiver_stall_pct = receiver_pct;
        walk_traffic(PHASE_ITEMS);
        wait_idle();
    endtask

    task automatic test_backpressure();
        write_root(rand64());
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_left <= HOLD_CYCLES;
        walk_traffic(60);
        wait_idle();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phase(0, 0, '0);
        test_random_phase(61, 0, '1);
        test_random_phase(0, 61, rand64());
        test_random_phase(26, 26, rand64());
        test_backpressure();
        $display("Ran %0d transactions in, %0d out: %0d reads, %0d translations, %0d faults.",
                 items_sent, reads_seen + done_seen + faults_seen,
                 reads_seen, done_seen, faults_seen);
        $display("Covered root base extremes, out-of-turn inputs, idle and stall mixes and a long output stall.");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
